### sv/running_sample_statistics_unit_macros.svh
// Assertion macros for the running sample statistics unit.
// Both macros assume clk_i and rst_ni are visible where they are used.
`ifndef RUNNING_SAMPLE_STATISTICS_UNIT_MACROS_SVH
`define RUNNING_SAMPLE_STATISTICS_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define RSS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("running_sample_statistics_unit: check failed");
`define RSS_ASSERT_NEVER(label, expr) `RSS_ASSERT(label, !(expr))
`else
`define RSS_ASSERT(label, prop)
`define RSS_ASSERT_NEVER(label, expr)
`endif

`endif

### sv/rss_pkg.sv
`default_nettype none

package rss_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned MEAN_W    = 32;
  localparam int unsigned VAR_W     = 46;

  localparam logic [MEAN_W-1:0] MEAN_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [MEAN_W-1:0] MEAN_NEG_MAG = 32'h8000_0000;
  localparam logic [VAR_W-1:0]  VAR_MAX      = {VAR_W{1'b1}};

  typedef enum logic [1:0] {
    OP_MUL,
    OP_SUB,
    OP_DIV
  } rss_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_SS,
    S_MUL_NSQ,
    S_SUB,
    S_MUL_NN,
    S_DIV_VAR,
    S_DIV_MEAN
  } rss_state_e;

  typedef struct packed {
    logic    start;
    rss_op_e op;
  } rss_alu_cmd_t;

endpackage

`default_nettype wire

### sv/rss_accum.sv
`default_nettype none

module rss_accum
  import rss_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_COUNT   = 16,
  parameter int unsigned CNT_W       = 5,
  parameter int unsigned SUM_W       = 21,
  parameter int unsigned SQ_W        = 35
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          last_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0]      nx_max_o,
  output logic signed [SAMPLE_BITS-1:0]      nx_min_o,
  output logic signed [SUM_W-1:0]            nx_sum_o,
  output logic [SQ_W-1:0]                    nx_sumsq_o,
  output logic [CNT_W-1:0]                   nx_cnt_o,
  output logic                               nx_ovf_o
);

  localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  logic signed [SAMPLE_BITS-1:0]   max_q, min_q;
  logic signed [SUM_W-1:0]         sum_q;
  logic [SQ_W-1:0]                 sumsq_q;
  logic [CNT_W-1:0]                cnt_q;
  logic                            ovf_q;
  logic                            take;
  logic signed [2*SAMPLE_BITS-1:0] sq_s;
  logic [2*SAMPLE_BITS-1:0]        sq_u;

  // drop samples once the set is full
  assign take = cnt_q < CNT_W'(MAX_COUNT);
  assign sq_s = sample_i * sample_i;
  assign sq_u = sq_s;

  assign nx_max_o   = (take && (sample_i > max_q)) ? sample_i : max_q;
  assign nx_min_o   = (take && (sample_i < min_q)) ? sample_i : min_q;
  assign nx_sum_o   = take ? (sum_q + SUM_W'(sample_i)) : sum_q;
  assign nx_sumsq_o = take ? (sumsq_q + SQ_W'(sq_u)) : sumsq_q;
  assign nx_cnt_o   = take ? (cnt_q + CNT_W'(1)) : cnt_q;
  assign nx_ovf_o   = ovf_q | ~take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= MOST_NEG;
      min_q   <= MOST_POS;
      sum_q   <= '0;
      sumsq_q <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (en_i) begin
      if (last_i) begin
        max_q   <= MOST_NEG;
        min_q   <= MOST_POS;
        sum_q   <= '0;
        sumsq_q <= '0;
        cnt_q   <= '0;
        ovf_q   <= 1'b0;
      end else begin
        max_q   <= nx_max_o;
        min_q   <= nx_min_o;
        sum_q   <= nx_sum_o;
        sumsq_q <= nx_sumsq_o;
        cnt_q   <= nx_cnt_o;
        ovf_q   <= nx_ovf_o;
      end
    end
  end

endmodule

`default_nettype wire

### sv/rss_alu.sv
`default_nettype none

module rss_alu
  import rss_pkg::*;
#(
  parameter int unsigned W    = 58,
  parameter int unsigned DS_W = 10,
  parameter int unsigned IT_W = 6
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rss_alu_cmd_t    cmd_i,
  input  wire logic [W-1:0]    opa_i,
  input  wire logic [W-1:0]    opb_i,
  input  wire logic [IT_W-1:0] iters_i,
  output logic                 done_o,
  output logic [W-1:0]         result_o
);

  localparam int unsigned ADD_W = W + 1;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  rss_op_e         op_q, op_d;
  logic [IT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]    acc_q, acc_d;
  logic [W-1:0]    x_q, x_d;
  logic [W-1:0]    y_q, y_d;
  logic [DS_W-1:0] d_q, d_d;

  logic [W-1:0]     add_a, add_b, trial;
  logic             add_sub, carry;
  logic [ADD_W-1:0] add_res;

  // one shared adder: shift-add multiply, subtract, restoring divide
  always_comb begin
    add_a   = acc_q;
    add_b   = x_q;
    add_sub = 1'b0;
    trial   = {acc_q[W-2:0], x_q[W-1]};
    case (op_q)
      OP_SUB: add_sub = 1'b1;
      OP_DIV: begin
        add_a   = trial;
        add_b   = W'(d_q);
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign add_res = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + ADD_W'(add_sub);
  assign carry   = add_res[W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    d_d    = d_q;
    if (busy_q) begin
      cnt_d = cnt_q - IT_W'(1);
      if (cnt_q == IT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      case (op_q)
        OP_MUL: begin
          if (y_q[0]) acc_d = add_res[W-1:0];
          x_d = x_q << 1;
          y_d = y_q >> 1;
        end
        // clamp a negative difference to zero
        OP_SUB: acc_d = carry ? add_res[W-1:0] : '0;
        OP_DIV: begin
          acc_d = carry ? add_res[W-1:0] : trial;
          x_d   = {x_q[W-2:0], carry};
        end
        default: ;
      endcase
    end else if (cmd_i.start) begin
      busy_d = 1'b1;
      op_d   = cmd_i.op;
      cnt_d  = iters_i;
      acc_d  = (cmd_i.op == OP_SUB) ? opa_i : '0;
      x_d    = (cmd_i.op == OP_SUB) ? opb_i : opa_i;
      y_d    = opb_i;
      d_d    = opb_i[DS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    d_q   <= d_d;
  end

  assign done_o   = done_q;
  assign result_o = (op_q == OP_DIV) ? x_q : acc_q;

endmodule

`default_nettype wire

### sv/rss_ctrl.sv
`default_nettype none

module rss_ctrl
  import rss_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned CNT_W       = 5,
  parameter int unsigned SUM_W       = 21,
  parameter int unsigned SQ_W        = 35,
  parameter int unsigned W           = 58,
  parameter int unsigned IT_W        = 6
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          last_i,
  output logic                               in_ready_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  input  wire logic signed [SAMPLE_BITS-1:0] nx_max_i,
  input  wire logic signed [SAMPLE_BITS-1:0] nx_min_i,
  input  wire logic signed [SUM_W-1:0]       nx_sum_i,
  input  wire logic [SQ_W-1:0]               nx_sumsq_i,
  input  wire logic [CNT_W-1:0]              nx_cnt_i,
  input  wire logic                          nx_ovf_i,
  output rss_alu_cmd_t                       cmd_o,
  output logic [W-1:0]                       opa_o,
  output logic [W-1:0]                       opb_o,
  output logic [IT_W-1:0]                    iters_o,
  input  wire logic                          alu_done_i,
  input  wire logic [W-1:0]                  alu_res_i,
  output logic signed [SAMPLE_BITS-1:0]      max_value_o,
  output logic signed [SAMPLE_BITS-1:0]      min_value_o,
  output logic [MEAN_W-1:0]                  mean_q16_o,
  output logic [VAR_W-1:0]                   variance_q16_o,
  output logic [CNT_W-1:0]                   sample_count_o,
  output logic                               overflow_o
);

  localparam int unsigned CMP_W = (W > VAR_W) ? W : VAR_W;

  rss_state_e state_q, state_d;
  logic       launched_q, launched_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, close_set;

  logic signed [SUM_W-1:0]       fin_sum_q;
  logic [SQ_W-1:0]               fin_sumsq_q;
  logic [W-1:0]                  prod_q, sq_q;
  logic signed [SAMPLE_BITS-1:0] max_q, min_q;
  logic [CNT_W-1:0]              count_q;
  logic                          ovf_q;
  logic [MEAN_W-1:0]             mean_q;
  logic [VAR_W-1:0]              var_q;

  logic [SUM_W-1:0]  sum_u, mag;
  logic              neg;
  logic [CMP_W-1:0]  q_ext;
  logic [MEAN_W-1:0] mean_lim, mean_mag, mean_val;
  logic [VAR_W-1:0]  var_val;

  // a closing sample waits until the previous result has been taken
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || !last_i);
  assign accept     = in_valid_i && in_ready_o;
  assign close_set  = accept && last_i;

  assign sum_u = fin_sum_q;
  assign neg   = sum_u[SUM_W-1];
  assign mag   = neg ? (~sum_u + SUM_W'(1)) : sum_u;

  assign q_ext    = CMP_W'(alu_res_i);
  assign mean_lim = neg ? MEAN_NEG_MAG : MEAN_POS_MAX;
  assign mean_mag = (q_ext > CMP_W'(mean_lim)) ? mean_lim : MEAN_W'(alu_res_i);
  assign mean_val = neg ? (~mean_mag + MEAN_W'(1)) : mean_mag;
  assign var_val  = (q_ext > CMP_W'(VAR_MAX)) ? VAR_MAX : VAR_W'(alu_res_i);

  // next state
  always_comb begin
    state_d     = state_q;
    launched_d  = launched_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (alu_done_i) begin
      launched_d = 1'b0;
    end else if (cmd_o.start) begin
      launched_d = 1'b1;
    end
    unique case (state_q)
      S_IDLE:     if (close_set) state_d = S_MUL_SS;
      S_MUL_SS:   if (alu_done_i) state_d = S_MUL_NSQ;
      S_MUL_NSQ:  if (alu_done_i) state_d = S_SUB;
      S_SUB:      if (alu_done_i) state_d = S_MUL_NN;
      S_MUL_NN:   if (alu_done_i) state_d = S_DIV_VAR;
      S_DIV_VAR:  if (alu_done_i) state_d = S_DIV_MEAN;
      S_DIV_MEAN: begin
        if (alu_done_i) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // operands for the shared unit
  always_comb begin
    cmd_o.start = (state_q != S_IDLE) && !launched_q;
    cmd_o.op    = OP_MUL;
    opa_o       = '0;
    opb_o       = '0;
    iters_o     = IT_W'(1);
    unique case (state_q)
      S_MUL_SS: begin
        opa_o   = W'(mag);
        opb_o   = W'(mag);
        iters_o = IT_W'(SUM_W);
      end
      S_MUL_NSQ: begin
        opa_o   = W'(fin_sumsq_q);
        opb_o   = W'(count_q);
        iters_o = IT_W'(CNT_W);
      end
      S_SUB: begin
        cmd_o.op = OP_SUB;
        opa_o    = prod_q;
        opb_o    = sq_q;
      end
      S_MUL_NN: begin
        opa_o   = W'(count_q);
        opb_o   = W'(count_q);
        iters_o = IT_W'(CNT_W);
      end
      S_DIV_VAR: begin
        cmd_o.op = OP_DIV;
        opa_o    = prod_q << FRAC_BITS;
        opb_o    = sq_q;
        iters_o  = IT_W'(W);
      end
      S_DIV_MEAN: begin
        cmd_o.op = OP_DIV;
        opa_o    = W'(mag) << FRAC_BITS;
        opb_o    = W'(count_q);
        iters_o  = IT_W'(W);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launched_q  <= launched_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (close_set) begin
      fin_sum_q   <= nx_sum_i;
      fin_sumsq_q <= nx_sumsq_i;
      max_q       <= nx_max_i;
      min_q       <= nx_min_i;
      count_q     <= nx_cnt_i;
      ovf_q       <= nx_ovf_i;
    end
    if (alu_done_i) begin
      case (state_q)
        S_MUL_SS:   sq_q   <= alu_res_i;
        S_MUL_NSQ:  prod_q <= alu_res_i;
        S_SUB:      prod_q <= alu_res_i;
        S_MUL_NN:   sq_q   <= alu_res_i;
        S_DIV_VAR:  var_q  <= var_val;
        S_DIV_MEAN: mean_q <= mean_val;
        default: ;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign max_value_o    = max_q;
  assign min_value_o    = min_q;
  assign mean_q16_o     = mean_q;
  assign variance_q16_o = var_q;
  assign sample_count_o = count_q;
  assign overflow_o     = ovf_q;

endmodule

`default_nettype wire

### sv/running_sample_statistics_unit.sv
// Ordinary samples: one transfer per cycle, back to back while the sequencer is idle,
// folded into the running sums. Closing sample: the shared adder runs two multiplies,
// a subtract, a multiply and two bit-serial divides, and the input stalls until it is
// done and the result is valid.
// Another set may stream in while a result waits, but its closing sample waits for it.
// Reset (async, active low) clears the accumulators and the sequencer; no clearing pass.
`default_nettype none

module running_sample_statistics_unit
  import rss_pkg::*;
#(
  parameter int unsigned MAX_COUNT   = 16,
  parameter int unsigned SAMPLE_BITS = 16,
  localparam int unsigned CNT_W      = $clog2(MAX_COUNT + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                          last_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]      max_value_o,
  output logic signed [SAMPLE_BITS-1:0]      min_value_o,
  output logic signed [MEAN_W-1:0]           mean_q16_o,
  output logic [VAR_W-1:0]                   variance_q16_o,
  output logic [CNT_W-1:0]                   sample_count_o,
  output logic                               overflow_o
);

`include "running_sample_statistics_unit_macros.svh"

  localparam int unsigned SUM_W = SAMPLE_BITS + CNT_W;
  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS - 2 + CNT_W;
  localparam int unsigned ALU_W = 2 * SUM_W + FRAC_BITS;
  localparam int unsigned DS_W  = 2 * CNT_W;
  localparam int unsigned IT_W  = $clog2(ALU_W + 1);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COUNT);

  logic                          accept;
  logic signed [SAMPLE_BITS-1:0] nx_max, nx_min;
  logic signed [SUM_W-1:0]       nx_sum;
  logic [SQ_W-1:0]               nx_sumsq;
  logic [CNT_W-1:0]              nx_cnt;
  logic                          nx_ovf;
  rss_alu_cmd_t                  alu_cmd;
  logic [ALU_W-1:0]              alu_a, alu_b, alu_res;
  logic [IT_W-1:0]               alu_iters;
  logic                          alu_done;

  assign accept = in_valid_i && in_ready_o;

  rss_accum #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_COUNT   (MAX_COUNT),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W),
    .SQ_W        (SQ_W)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (accept),
    .last_i     (last_i),
    .sample_i   (sample_i),
    .nx_max_o   (nx_max),
    .nx_min_o   (nx_min),
    .nx_sum_o   (nx_sum),
    .nx_sumsq_o (nx_sumsq),
    .nx_cnt_o   (nx_cnt),
    .nx_ovf_o   (nx_ovf)
  );

  rss_alu #(
    .W    (ALU_W),
    .DS_W (DS_W),
    .IT_W (IT_W)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (alu_cmd),
    .opa_i    (alu_a),
    .opb_i    (alu_b),
    .iters_i  (alu_iters),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

  rss_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W),
    .SQ_W        (SQ_W),
    .W           (ALU_W),
    .IT_W        (IT_W)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .last_i         (last_i),
    .in_ready_o     (in_ready_o),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .nx_max_i       (nx_max),
    .nx_min_i       (nx_min),
    .nx_sum_i       (nx_sum),
    .nx_sumsq_i     (nx_sumsq),
    .nx_cnt_i       (nx_cnt),
    .nx_ovf_i       (nx_ovf),
    .cmd_o          (alu_cmd),
    .opa_o          (alu_a),
    .opb_o          (alu_b),
    .iters_o        (alu_iters),
    .alu_done_i     (alu_done),
    .alu_res_i      (alu_res),
    .max_value_o    (max_value_o),
    .min_value_o    (min_value_o),
    .mean_q16_o     (mean_q16_o),
    .variance_q16_o (variance_q16_o),
    .sample_count_o (sample_count_o),
    .overflow_o     (overflow_o)
  );

  // a closing transfer starts the sequence, which holds off the input
  `RSS_ASSERT(a_close_stalls, in_valid_i && in_ready_o && last_i |=> !in_ready_o)
  `RSS_ASSERT(a_count_range, out_valid_o |-> (sample_count_o != '0) && (sample_count_o <= CNT_MAX))
  `RSS_ASSERT_NEVER(a_min_above_max, out_valid_o && (min_value_o > max_value_o))

endmodule

`default_nettype wire
